/* sv/bsft_pkg.sv */
// Shared types and constants of the B-spline forward-difference tessellator.
// Depends on nothing; bsft_dp, bsft_ctl, the top unit and the bench use it.
package bsft_pkg;

  // step count register
  localparam int STEPS_W = 7;
  localparam logic [STEPS_W-1:0] STEPS_RESET = 7'd17;

  // configuration register indexes
  localparam logic REG_STEPS = 1'b0;

  // divisions done for each span, in issue order
  typedef enum logic [1:0] {
    SEL_BASE = 2'd0,  // first vertex, divided by six
    SEL_D1   = 2'd1,  // first difference
    SEL_D2   = 2'd2,  // second difference
    SEL_D3   = 2'd3   // third difference
  } dsel_t;

  // controller to datapath
  typedef struct packed {
    logic       accept;     // point word taken this cycle
    logic       store;      // point only fills the window
    logic [1:0] slot;       // window slot for a stored point
    logic       prep1;      // first product stage
    logic       prep2;      // second product stage
    logic       div_start;  // launch the dividers
    dsel_t      div_sel;    // which value to divide
    logic       fix;        // scale the base remainder
    logic       emit;       // load a vertex and step the differences
    logic       last;       // vertex closes the span
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_done;  // divider results valid
    logic out_free;  // output register can take a vertex
    logic last;      // next vertex is the last of the span
    logic n_zero;    // current step count gives no vertices
  } ctl_status_t;

endpackage

/* sv/bsft_ifs.sv */
// Handshake channels of the tessellator: control points in, vertices out.
// Stand-alone; widths set by the W parameter.
interface bsft_point_if #(parameter int W = 32);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] point_x;
  logic signed [W-1:0] point_y;
  logic signed [W-1:0] point_z;
  logic                curve_start;

  modport source (output valid, point_x, point_y, point_z, curve_start, input ready);
  modport sink   (input valid, point_x, point_y, point_z, curve_start, output ready);
endinterface

interface bsft_vertex_if #(parameter int W = 32);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] vertex_x;
  logic signed [W-1:0] vertex_y;
  logic signed [W-1:0] vertex_z;
  logic                span_end;

  modport source (output valid, vertex_x, vertex_y, vertex_z, span_end, input ready);
  modport sink   (input valid, vertex_x, vertex_y, vertex_z, span_end, output ready);
endinterface

/* sv/bsft_div.sv */
// Restoring divider, one quotient bit a cycle, floor rounding for signed dividends.
// Uses no package items; instantiated by bsft_dp.
module bsft_div #(
  parameter int XW  = 51,
  parameter int DVW = 24,
  parameter int QW  = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic signed [XW-1:0]  dividend,
  input  logic        [DVW-1:0] divisor,
  output logic                  done,
  output logic        [QW-1:0]  quot,
  output logic        [DVW-1:0] rem
);

  localparam int CNTW = $clog2(XW + 1);

  logic            busy;
  logic [CNTW-1:0] cnt;
  logic [XW-1:0]   mag;
  logic [DVW-1:0]  part;
  logic [DVW-1:0]  dvs;
  logic            neg;
  logic [DVW:0]    trial;
  logic            fits;

  // one restoring step
  assign trial = {part, mag[XW-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNTW'(XW);
        neg  <= dividend[XW-1];
        mag  <= dividend[XW-1] ? XW'(-dividend) : XW'(dividend);
        part <= '0;
        dvs  <= divisor;
      end else if (busy) begin
        part <= fits ? DVW'(trial - {1'b0, dvs}) : DVW'(trial);
        mag  <= {mag[XW-2:0], fits};
        cnt  <= cnt - CNTW'(1);
        if (cnt == CNTW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // floor correction for negative dividends
  always_comb begin
    if (neg && (part != '0)) begin
      quot = QW'(~mag);
      rem  = dvs - part;
    end else if (neg) begin
      quot = QW'(-mag);
      rem  = part;
    end else begin
      quot = QW'(mag);
      rem  = part;
    end
  end

endmodule

/* sv/bsft_dp.sv */
// Datapath: point window, span coefficients, dividers, forward-difference
// accumulators and the output register. Uses bsft_pkg and bsft_div.
module bsft_dp #(
  parameter int CW        = 32,
  parameter int MAX_STEPS = 65
) (
  input  logic                          clk,
  input  logic                          rst,
  input  bsft_pkg::ctl_cmd_t            cmd,
  output bsft_pkg::ctl_status_t         status,
  input  logic [bsft_pkg::STEPS_W-1:0]  steps,
  input  logic signed [CW-1:0]          in_x,
  input  logic signed [CW-1:0]          in_y,
  input  logic signed [CW-1:0]          in_z,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [CW-1:0]          out_x,
  output logic signed [CW-1:0]          out_y,
  output logic signed [CW-1:0]          out_z,
  output logic                          out_end
);

  localparam int NW  = $clog2(MAX_STEPS);
  localparam int KW  = CW + 4;
  localparam int BNW = KW + NW;
  localparam int CNW = KW + 2 * NW;
  localparam int XW  = CW + 2 * NW + 5;
  localparam int DVW = 3 * NW + 3;

  logic signed [CW-1:0]  pin [3];
  logic signed [CW-1:0]  win [3][3];
  logic signed [KW-1:0]  e0 [3], e1 [3], e2 [3], e3 [3];
  logic signed [KW-1:0]  tt [3], uu [3], vv [3];
  logic signed [KW-1:0]  ka [3], kb [3], kc [3], ke [3];
  logic signed [KW-1:0]  ca [3], cb [3], cc [3], ce [3];
  logic signed [BNW-1:0] bn [3], cn [3];
  logic signed [CNW-1:0] cn2 [3];
  logic signed [XW-1:0]  xa [3], a6 [3], dvd [3];
  logic [NW-1:0]         n_cur, n_r, vcnt;
  logic [2*NW-1:0]       nn;
  logic [3*NW-1:0]       n3;
  logic [DVW-1:0]        d, dvs;
  int                    se;
  bsft_pkg::dsel_t       sel_r;
  logic                  div_done [3];
  logic [CW-1:0]         dq [3];
  logic [DVW-1:0]        dr [3];
  logic [CW-1:0]         qs [3], q1 [3], q2 [3], q3 [3];
  logic [DVW-1:0]        rs [3], r1 [3], r2 [3], r3 [3];
  logic [DVW:0]          s0 [3], s1 [3], s2 [3];
  logic                  c0 [3], c1 [3], c2 [3];

  assign pin[0] = in_x;
  assign pin[1] = in_y;
  assign pin[2] = in_z;

  // clamp the step count and take the span length
  always_comb begin
    se = int'(steps);
    if (se < 1) se = 1;
    if (se > MAX_STEPS) se = MAX_STEPS;
    n_cur = NW'(se - 1);
  end

  // span coefficients from the window and the new point
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      e0[a] = KW'(win[0][a]);
      e1[a] = KW'(win[1][a]);
      e2[a] = KW'(win[2][a]);
      e3[a] = KW'(pin[a]);
      tt[a] = e1[a] - e2[a];
      uu[a] = e0[a] + e2[a] - (e1[a] <<< 1);
      vv[a] = e2[a] - e0[a];
      ka[a] = (tt[a] <<< 1) + tt[a] + e3[a] - e0[a];
      kb[a] = (uu[a] <<< 1) + uu[a];
      kc[a] = (vv[a] <<< 1) + vv[a];
      ke[a] = e0[a] + (e1[a] <<< 2) + e2[a];
    end
  end

  // window and coefficient registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      if (cmd.store) begin
        for (int a = 0; a < 3; a++) win[cmd.slot][a] <= pin[a];
      end else begin
        n_r <= n_cur;
        for (int a = 0; a < 3; a++) begin
          win[0][a] <= win[1][a];
          win[1][a] <= win[2][a];
          win[2][a] <= pin[a];
          ca[a] <= ka[a];
          cb[a] <= kb[a];
          cc[a] <= kc[a];
          ce[a] <= ke[a];
        end
      end
    end
  end

  // products of the coefficients with the span length
  always_ff @(posedge clk) begin
    if (cmd.prep1) begin
      nn <= (2*NW)'(n_r) * (2*NW)'(n_r);
      for (int a = 0; a < 3; a++) begin
        bn[a] <= $signed(BNW'(cb[a])) * $signed(BNW'({1'b0, n_r}));
        cn[a] <= $signed(BNW'(cc[a])) * $signed(BNW'({1'b0, n_r}));
      end
    end
    if (cmd.prep2) begin
      n3 <= (3*NW)'(nn) * (3*NW)'(n_r);
      for (int a = 0; a < 3; a++)
        cn2[a] <= $signed(CNW'(cn[a])) * $signed(CNW'({1'b0, n_r}));
    end
  end

  // divisor 6 n^3
  assign d = DVW'({n3, 2'b00}) + DVW'({n3, 1'b0});

  // dividend and divisor selection
  always_comb begin
    dvs = (cmd.div_sel == bsft_pkg::SEL_BASE) ? DVW'(6) : d;
    for (int a = 0; a < 3; a++) begin
      xa[a] = XW'(ca[a]);
      a6[a] = (xa[a] <<< 2) + (xa[a] <<< 1);
      case (cmd.div_sel)
        bsft_pkg::SEL_BASE: dvd[a] = XW'(ce[a]) + XW'(3);
        bsft_pkg::SEL_D1:   dvd[a] = xa[a] + XW'(bn[a]) + XW'(cn2[a]);
        bsft_pkg::SEL_D2:   dvd[a] = a6[a] + (XW'(bn[a]) <<< 1);
        default:            dvd[a] = a6[a];
      endcase
    end
  end

  for (genvar g = 0; g < 3; g++) begin : g_lane
    bsft_div #(.XW(XW), .DVW(DVW), .QW(CW)) u_div (
      .clk      (clk),
      .rst      (rst),
      .start    (cmd.div_start),
      .dividend (dvd[g]),
      .divisor  (dvs),
      .done     (div_done[g]),
      .quot     (dq[g]),
      .rem      (dr[g])
    );
  end

  // mixed quotient/remainder sums for one forward-difference step
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      s0[a] = {1'b0, rs[a]} + {1'b0, r1[a]};
      s1[a] = {1'b0, r1[a]} + {1'b0, r2[a]};
      s2[a] = {1'b0, r2[a]} + {1'b0, r3[a]};
      c0[a] = s0[a] >= {1'b0, d};
      c1[a] = s1[a] >= {1'b0, d};
      c2[a] = s2[a] >= {1'b0, d};
    end
  end

  // accumulator registers
  always_ff @(posedge clk) begin
    if (cmd.div_start) sel_r <= cmd.div_sel;
    if (div_done[0]) begin
      for (int a = 0; a < 3; a++) begin
        case (sel_r)
          bsft_pkg::SEL_BASE: begin qs[a] <= dq[a]; rs[a] <= dr[a]; end
          bsft_pkg::SEL_D1:   begin q1[a] <= dq[a]; r1[a] <= dr[a]; end
          bsft_pkg::SEL_D2:   begin q2[a] <= dq[a]; r2[a] <= dr[a]; end
          default:            begin q3[a] <= dq[a]; r3[a] <= dr[a]; end
        endcase
      end
    end
    if (cmd.fix) begin
      for (int a = 0; a < 3; a++) rs[a] <= DVW'(rs[a] * DVW'(n3));
    end
    if (cmd.prep1) vcnt <= '0;
    if (cmd.emit) begin
      vcnt <= vcnt + NW'(1);
      for (int a = 0; a < 3; a++) begin
        qs[a] <= qs[a] + q1[a] + CW'(c0[a]);
        rs[a] <= c0[a] ? DVW'(s0[a] - {1'b0, d}) : DVW'(s0[a]);
        q1[a] <= q1[a] + q2[a] + CW'(c1[a]);
        r1[a] <= c1[a] ? DVW'(s1[a] - {1'b0, d}) : DVW'(s1[a]);
        q2[a] <= q2[a] + q3[a] + CW'(c2[a]);
        r2[a] <= c2[a] ? DVW'(s2[a] - {1'b0, d}) : DVW'(s2[a]);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_x   <= qs[0];
      out_y   <= qs[1];
      out_z   <= qs[2];
      out_end <= cmd.last;
    end
  end

  assign status.div_done = div_done[0];
  assign status.out_free = !out_valid || out_ready;
  assign status.last     = (vcnt == n_r - NW'(1));
  assign status.n_zero   = (n_cur == '0);

endmodule

/* sv/bsft_ctl.sv */
// Controller: point counting, span sequencing, divider issue and vertex emission.
// Uses bsft_pkg command and status types.
module bsft_ctl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic                   curve_start,
  output logic                   in_ready,
  input  bsft_pkg::ctl_status_t  status,
  output bsft_pkg::ctl_cmd_t     cmd
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_PREP1, ST_PREP2, ST_DIV_GO, ST_DIV_WAIT, ST_FIX, ST_EMIT
  } state_t;

  state_t          state, state_next;
  logic [1:0]      seen, seen_next, seen_eff;
  bsft_pkg::dsel_t sel, sel_next;

  assign in_ready = (state == ST_IDLE);
  assign seen_eff = curve_start ? 2'd0 : seen;

  // next state and commands
  always_comb begin
    state_next = state;
    seen_next  = seen;
    sel_next   = sel;
    cmd        = '0;
    cmd.div_sel = sel;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (seen_eff != 2'd3) begin
            cmd.store = 1'b1;
            cmd.slot  = seen_eff;
            seen_next = seen_eff + 2'd1;
          end else begin
            seen_next = 2'd3;
            if (!status.n_zero) state_next = ST_PREP1;
          end
        end
      end
      ST_PREP1: begin
        cmd.prep1  = 1'b1;
        state_next = ST_PREP2;
      end
      ST_PREP2: begin
        cmd.prep2  = 1'b1;
        sel_next   = bsft_pkg::SEL_BASE;
        state_next = ST_DIV_GO;
      end
      ST_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_next    = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (status.div_done) begin
          if (sel == bsft_pkg::SEL_D3) begin
            state_next = ST_FIX;
          end else begin
            sel_next   = bsft_pkg::dsel_t'(sel + 2'd1);
            state_next = ST_DIV_GO;
          end
        end
      end
      ST_FIX: begin
        cmd.fix    = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          cmd.last = status.last;
          if (status.last) state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      seen  <= 2'd0;
      sel   <= bsft_pkg::SEL_BASE;
    end else begin
      state <= state_next;
      seen  <= seen_next;
      sel   <= sel_next;
    end
  end

endmodule

/* sv/bspline_forward_difference_tessellator_unit.sv */
// Uniform cubic B-spline tessellator. Control points come in one word at a
// time; the first three points of a curve (curve_start opens a curve) only
// fill the window and give nothing. Every later point closes a span and gives
// steps_per_span-1 vertices (steps_per_span clamped to 1..MAX_STEPS), exact
// to the rounding of Q16.16, the last one flagged with span_end. For such a
// point the span products are formed, then four divisions of XW = COORD_WIDTH
// + 2*clog2(MAX_STEPS) + 5 bit dividends, the start value by six and the
// differences by 6n^3, run one bit a cycle on a shared radix-2 divider per
// axis; the start remainder is scaled, then one vertex leaves per cycle as
// the output side allows. A step count of one gives no vertices; the point
// only moves the window. The next point is taken as soon as the last vertex
// sits in the output register. steps_per_span is the only register, at
// address 0. Depends on bsft_pkg, bsft_ifs, bsft_div, bsft_dp and bsft_ctl.
module bspline_forward_difference_tessellator_unit #(
  parameter int MAX_STEPS   = 65,
  parameter int COORD_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst,
  bsft_point_if.sink          point_ch,
  bsft_vertex_if.source       vertex_ch,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  logic [bsft_pkg::STEPS_W-1:0] steps_per_span;
  bsft_pkg::ctl_cmd_t           cmd;
  bsft_pkg::ctl_status_t        status;

  // configuration register
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      steps_per_span <= bsft_pkg::STEPS_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == bsft_pkg::REG_STEPS)) begin
      steps_per_span <= pwdata[bsft_pkg::STEPS_W-1:0];
    end
  end
  assign prdata = (paddr[2] == bsft_pkg::REG_STEPS) ? 32'(steps_per_span) : 32'd0;

  bsft_ctl u_ctl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (point_ch.valid),
    .curve_start (point_ch.curve_start),
    .in_ready    (point_ch.ready),
    .status      (status),
    .cmd         (cmd)
  );

  bsft_dp #(.CW(COORD_WIDTH), .MAX_STEPS(MAX_STEPS)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .steps     (steps_per_span),
    .in_x      (point_ch.point_x),
    .in_y      (point_ch.point_y),
    .in_z      (point_ch.point_z),
    .out_valid (vertex_ch.valid),
    .out_ready (vertex_ch.ready),
    .out_x     (vertex_ch.vertex_x),
    .out_y     (vertex_ch.vertex_y),
    .out_z     (vertex_ch.vertex_z),
    .out_end   (vertex_ch.span_end)
  );

  // a vertex is never loaded over one still waiting
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> status.out_free) else $error("vertex overwritten");

  // the dividers never finish in the cycle after launch
  a_div_len: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |=> !status.div_done) else $error("divider finished early");

  // after the last vertex of a span the input side reopens
  a_reopen: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && cmd.last) |=> point_ch.ready) else $error("input not reopened");

endmodule

/* verif/bspline_forward_difference_tessellator_unit_test.sv */
// Self-checking bench for the B-spline forward-difference tessellator:
// control points in, vertices checked against an exact rounding predictor.
// Depends on bsft_pkg, bsft_ifs and the unit under test.
module bspline_forward_difference_tessellator_unit_test;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW        = 32;
  localparam int STEP_MAX  = 65;
  localparam int SETTLE    = 400;  // cycles past the block's per-point work

  typedef struct {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic                 last;
  } vertex_t;

  // Predicts vertices for every accepted point and checks what comes out
  class span_scoreboard;
    longint    window[9];
    int        held;
    int        steps;
    vertex_t   pending[$];
    int        errors;

    function new();
      foreach (window[k]) window[k] = 0;
      held   = 0;
      steps  = bsft_pkg::STEPS_RESET;
      errors = 0;
    endfunction

    // exact weighted sum divided by d, halves rounded up
    function longint blend(longint w[4], longint p[4], longint d);
      longint num, q;
      num = d / 2;
      for (int k = 0; k < 4; k++) num += w[k] * p[k];
      q = num / d;
      if (num % d < 0) q -= 1;
      return q;
    endfunction

    function void note_point(logic signed [CW-1:0] px, logic signed [CW-1:0] py,
                             logic signed [CW-1:0] pz, logic start);
      longint  pt[3];
      longint  w[4];
      longint  p[4];
      longint  n, d, u;
      longint  res[3];
      int      s;
      vertex_t v;
      pt[0] = px; pt[1] = py; pt[2] = pz;
      if (start) begin
        foreach (window[k]) window[k] = 0;
        held = 0;
      end
      if (held >= 3) begin
        s = steps;
        if (s < 1) s = 1;
        if (s > STEP_MAX) s = STEP_MAX;
        n = s - 1;
        d = 6 * n * n * n;
        for (longint i = 0; i < n; i++) begin
          u = n - i;
          w[0] = u * u * u;
          w[1] = 3*i*i*i - 6*i*i*n + 4*n*n*n;
          w[2] = -3*i*i*i + 3*i*i*n + 3*i*n*n + n*n*n;
          w[3] = i * i * i;
          for (int a = 0; a < 3; a++) begin
            p[0] = window[a]; p[1] = window[3+a]; p[2] = window[6+a]; p[3] = pt[a];
            res[a] = blend(w, p, d);
          end
          v.x = res[0][CW-1:0];
          v.y = res[1][CW-1:0];
          v.z = res[2][CW-1:0];
          v.last = (i == n - 1);
          pending = {pending, v};
        end
        for (int k = 0; k < 6; k++) window[k] = window[k+3];
        for (int a = 0; a < 3; a++) window[6+a] = pt[a];
      end else begin
        for (int a = 0; a < 3; a++) window[held*3 + a] = pt[a];
        held++;
      end
    endfunction

    function void check_vertex(vertex_t got);
      vertex_t exp_v;
      if (pending.size() == 0) begin
        $display("%0t: unexpected vertex x=%0d y=%0d z=%0d end=%0b", $realtime,
                 got.x, got.y, got.z, got.last);
        errors++;
        return;
      end
      exp_v = pending.pop_front();
      if (got.x !== exp_v.x) begin
        $display("%0t: vertex_x expected %0d actual %0d", $realtime, exp_v.x, got.x);
        errors++;
      end
      if (got.y !== exp_v.y) begin
        $display("%0t: vertex_y expected %0d actual %0d", $realtime, exp_v.y, got.y);
        errors++;
      end
      if (got.z !== exp_v.z) begin
        $display("%0t: vertex_z expected %0d actual %0d", $realtime, exp_v.z, got.z);
        errors++;
      end
      if (got.last !== exp_v.last) begin
        $display("%0t: span_end expected %0b actual %0b", $realtime, exp_v.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  bsft_point_if  #(CW) point_ch();
  bsft_vertex_if #(CW) vertex_ch();

  bspline_forward_difference_tessellator_unit #(
    .MAX_STEPS(STEP_MAX), .COORD_WIDTH(CW)
  ) dut (
    .clk(clk), .rst(rst), .point_ch(point_ch), .vertex_ch(vertex_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  span_scoreboard sb = new();
  int send_idle = 37;
  int recv_idle = 55;

  // clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // hard stop
  initial begin
    #5ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // vertex sink: check accepted words, then pick the next ready level
  always @(posedge clk) begin
    vertex_t got;
    if (!rst && vertex_ch.valid && vertex_ch.ready) begin
      got.x = vertex_ch.vertex_x;
      got.y = vertex_ch.vertex_y;
      got.z = vertex_ch.vertex_z;
      got.last = vertex_ch.span_end;
      sb.check_vertex(got);
    end
    vertex_ch.ready <= ($urandom_range(0, 99) >= recv_idle);
  end

  // one point word, with random idle cycles in front
  task automatic send_point(logic [CW-1:0] px, logic [CW-1:0] py, logic [CW-1:0] pz,
                            logic start);
    while ($urandom_range(0, 99) < send_idle) begin
      point_ch.valid <= 1'b0;
      @(posedge clk);
    end
    point_ch.valid       <= 1'b1;
    point_ch.point_x     <= px;
    point_ch.point_y     <= py;
    point_ch.point_z     <= pz;
    point_ch.curve_start <= start;
    do @(posedge clk); while (!point_ch.ready);
    sb.note_point(px, py, pz, start);
  endtask

  // drop valid and wait until every vertex is out and the block has settled
  task automatic drain();
    point_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_steps(logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {bsft_pkg::REG_STEPS, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    sb.steps = value[bsft_pkg::STEPS_W-1:0];
  endtask

  function automatic logic [CW-1:0] rand_coord();
    case ($urandom_range(0, 3))
      0:       return $urandom_range(0, 2000) - 1000;
      1:       return {{8{1'b0}}, 24'($urandom)} - 32'h0080_0000;
      default: return $urandom;
    endcase
  endfunction

  // mostly whole curves of random length, some noise on curve_start
  task automatic random_points(int count);
    int len;
    int sent;
    sent = 0;
    while (sent < count) begin
      len = $urandom_range(4, 8);
      for (int k = 0; k < len && sent < count; k++) begin
        if ($urandom_range(0, 9) == 0)
          send_point(rand_coord(), rand_coord(), rand_coord(), 1'($urandom_range(0, 1)));
        else
          send_point(rand_coord(), rand_coord(), rand_coord(), k == 0);
        sent++;
      end
    end
  endtask

  initial begin
    rst                  <= 1'b1;
    psel                 <= 1'b0;
    penable              <= 1'b0;
    pwrite               <= 1'b0;
    paddr                <= '0;
    pwdata               <= '0;
    point_ch.valid       <= 1'b0;
    point_ch.point_x     <= '0;
    point_ch.point_y     <= '0;
    point_ch.point_z     <= '0;
    point_ch.curve_start <= 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset step count, points carried over from reset window
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 1'b0);
    send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0001_0000, 1'b0);
    send_point(32'h8000_0000, 32'h8000_0000, 32'hFFFF_0000, 1'b0);
    send_point(32'h0000_0001, 32'hFFFF_FFFF, 32'h5555_5555, 1'b0);
    // short curve that gives nothing, then a restart mid-window
    send_point(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 1'b1);
    send_point(32'hAAAA_AAAA, 32'h5555_5555, 32'h0000_0003, 1'b0);
    send_point(32'h0000_0005, 32'h0000_0007, 32'h0000_0009, 1'b1);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
    send_point(32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0002, 1'b0);
    drain();

    // step count above the limit saturates: 64 vertices per span
    write_steps(32'd127);
    random_points(6);
    drain();
    // zero acts as one: the window moves, nothing comes out
    write_steps(32'd0);
    random_points(8);
    drain();
    write_steps(32'd1);
    random_points(5);
    drain();
    write_steps(32'd5);
    random_points(25);
    drain();

    // swap idling sides
    send_idle = 55;
    recv_idle = 37;
    write_steps(32'd2);
    random_points(35);
    drain();
    write_steps(32'd65);
    random_points(5);
    drain();

    // full speed both ways
    send_idle = 0;
    recv_idle = 0;
    write_steps(32'd9);
    random_points(30);
    drain();

    if (sb.errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
